>>> hdl/mlws_pkg.sv
// ---------------------------------------------------------------------------
// mlws_pkg: shared types and constants
// Sizes of the window store, counters and sum, plus controller/datapath types.
// ---------------------------------------------------------------------------
package mlws_pkg;

   localparam int MAX_LEN    = 4096;
   localparam int VALUE_BITS = 16;
   localparam int IDX_BITS   = $clog2(MAX_LEN);
   localparam int CNT_BITS   = $clog2(MAX_LEN + 1);
   localparam int TOTAL_BITS = IDX_BITS + VALUE_BITS;
   localparam int TARGET_BITS = 32;
   localparam int LEN_BITS   = 13;

   localparam logic [TARGET_BITS-1:0] TARGET_RESET = TARGET_BITS'(1);

   typedef enum logic {
      ST_IDLE,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic qualify;
      logic last;
      logic rsp_busy;
   } status_type;

endpackage

>>> hdl/mlws_if.sv
// ---------------------------------------------------------------------------
// mlws channel interfaces
// Valid/ready channels for input items, results and the target register.
// ---------------------------------------------------------------------------
interface mlws_req_if;
   logic                             valid;
   logic                             ready;
   logic [mlws_pkg::VALUE_BITS-1:0]  value;
   logic                             last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface mlws_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mlws_pkg::LEN_BITS-1:0]  min_length;
   logic                           overflow;

   modport source (output valid, output min_length, output overflow, input ready);
   modport sink   (input valid, input min_length, input overflow, output ready);
endinterface

interface mlws_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mlws_pkg::TARGET_BITS-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/mlws_ctrl.sv
// ---------------------------------------------------------------------------
// mlws_ctrl: window controller
// Accepts an item, then pops while the window qualifies, then emits on last.
// ---------------------------------------------------------------------------
module mlws_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mlws_pkg::status_type  status,
   output mlws_pkg::cmd_type     cmd
);

   mlws_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         mlws_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push = 1'b1;
               state_in = mlws_pkg::ST_CHECK;
            end
         end
         mlws_pkg::ST_CHECK: begin
            if (status.qualify) begin
               cmd.pop = 1'b1;
            end else if (!status.last) begin
               state_in = mlws_pkg::ST_IDLE;
            end else if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = mlws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mlws_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/mlws_dp.sv
// ---------------------------------------------------------------------------
// mlws_dp: window datapath
// Ring store with head/tail, running sum, best length and result register.
// ---------------------------------------------------------------------------
module mlws_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [mlws_pkg::VALUE_BITS-1:0]  req_value,
   input  logic                             req_last,
   input  mlws_pkg::cmd_type                cmd,
   output mlws_pkg::status_type             status,
   mlws_rsp_if.source                       rsp_chan,
   mlws_csr_if.sink                         csr_chan
);

   localparam logic [mlws_pkg::IDX_BITS-1:0] LAST_SLOT =
      mlws_pkg::IDX_BITS'(mlws_pkg::MAX_LEN - 1);
   localparam logic [mlws_pkg::CNT_BITS-1:0] FULL_CNT  = mlws_pkg::CNT_BITS'(mlws_pkg::MAX_LEN);

   logic [mlws_pkg::VALUE_BITS-1:0]  store_mem [mlws_pkg::MAX_LEN];
   logic [mlws_pkg::VALUE_BITS-1:0]  rd_ff;

   logic [mlws_pkg::IDX_BITS-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [mlws_pkg::CNT_BITS-1:0]    count_ff, count_in, best_ff, best_in;
   logic [mlws_pkg::TOTAL_BITS-1:0]  total_ff, total_in;
   logic                             ovf_ff, ovf_in, last_ff, last_in;
   logic [mlws_pkg::TARGET_BITS-1:0] target_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mlws_pkg::LEN_BITS-1:0]    rsp_len_ff, rsp_len_in;
   logic                             rsp_ovf_ff, rsp_ovf_in;
   logic                             wr_en;

   function automatic logic [mlws_pkg::IDX_BITS-1:0] next_slot(
      input logic [mlws_pkg::IDX_BITS-1:0] slot
   );
      logic [mlws_pkg::IDX_BITS-1:0] nxt;
      nxt = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
      return nxt;
   endfunction

   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.min_length = rsp_len_ff;
   assign rsp_chan.overflow   = rsp_ovf_ff;

   assign status.qualify  = (count_ff != '0) &&
                            (mlws_pkg::TARGET_BITS'(total_ff) >= target_ff);
   assign status.last     = last_ff;
   assign status.rsp_busy = rsp_valid_ff && !rsp_chan.ready;

   assign wr_en = cmd.push;

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (cmd.push) begin
         last_in = req_last;
         tail_in = next_slot(tail_ff);
         if (count_ff == FULL_CNT) begin
            // store full: drop oldest in the same cycle
            total_in = total_ff - mlws_pkg::TOTAL_BITS'(rd_ff)
                       + mlws_pkg::TOTAL_BITS'(req_value);
            head_in  = next_slot(head_ff);
            ovf_in   = 1'b1;
         end else begin
            total_in = total_ff + mlws_pkg::TOTAL_BITS'(req_value);
            count_in = count_ff + 1'b1;
         end
      end else if (cmd.pop) begin
         if (best_ff == '0 || count_ff < best_ff) begin
            best_in = count_ff;
         end
         total_in = total_ff - mlws_pkg::TOTAL_BITS'(rd_ff);
         head_in  = next_slot(head_ff);
         count_in = count_ff - 1'b1;
      end else if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = mlws_pkg::LEN_BITS'(best_ff);
         rsp_ovf_in   = ovf_ff;
         head_in      = '0;
         tail_in      = '0;
         count_in     = '0;
         total_in     = '0;
         best_in      = '0;
         ovf_in       = 1'b0;
         last_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= mlws_pkg::TARGET_RESET;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            target_ff <= csr_chan.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // rd_ff always mirrors the entry at head_ff; bypass a write to that slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[tail_ff] <= req_value;
      end
      if (wr_en && tail_ff == head_in) begin
         rd_ff <= req_value;
      end else begin
         rd_ff <= store_mem[head_in];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("window count above capacity");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> count_ff != '0)
      else $error("pop from empty window");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (count_ff == '0 && total_ff == '0 && rsp_valid_ff))
      else $error("window not cleared after result");

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      best_ff <= FULL_CNT)
      else $error("best length above capacity");

endmodule

>>> hdl/min_length_window_sum.sv
// ---------------------------------------------------------------------------
// min_length_window_sum: shortest window reaching a target sum
// Sequence: an item is accepted in ST_IDLE, then checked in ST_CHECK (P pops),
// result shown in the cycle after the last check. A new item is taken only when
// the last one's checks are done; each value is popped at most once.
// A result still waiting on the result channel holds the last item's check.
// Reset (synchronous): clears window state and result, target_sum returns to 1;
// the window store itself is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module min_length_window_sum (
   input  logic        clock,
   input  logic        reset,
   mlws_req_if.sink    req_chan,
   mlws_rsp_if.source  rsp_chan,
   mlws_csr_if.sink    csr_chan
);

   mlws_pkg::cmd_type    cmd;
   mlws_pkg::status_type status;
   logic                 req_ready;

   assign req_chan.ready = req_ready;

   mlws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mlws_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_chan.value),
      .req_last  (req_chan.last),
      .cmd       (cmd),
      .status    (status),
      .rsp_chan  (rsp_chan),
      .csr_chan  (csr_chan)
   );

endmodule

>>> sim/min_length_window_sum_tb.sv
// ---------------------------------------------------------------------------
// min_length_window_sum_tb: self-checking bench for the shortest-window block
// Streams arrays of values under a range of target sums, predicts the
// shortest qualifying window and the overflow flag per array, and compares
// each result item against that prediction. Random idling on both channels.
// ---------------------------------------------------------------------------
module min_length_window_sum_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [mlws_pkg::VALUE_BITS-1:0] value;
      logic                            last;
   } array_item_type;

   typedef struct packed {
      logic [mlws_pkg::LEN_BITS-1:0] min_length;
      logic                          overflow;
   } window_result_type;

   logic clock;
   logic reset;

   mlws_req_if req_chan();
   mlws_rsp_if rsp_chan();
   mlws_csr_if csr_chan();

   min_length_window_sum DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   array_item_type       pending_values[$];
   window_result_type    expected_lengths[$];
   array_item_type       next_value;
   window_result_type    got_result;
   window_result_type    want_result;

   logic [mlws_pkg::VALUE_BITS-1:0]  window_values[$];
   longint unsigned                  window_sum = 0;
   logic [mlws_pkg::LEN_BITS-1:0]    shortest_len = '0;
   logic                             store_overflowed = 1'b0;
   logic [mlws_pkg::TARGET_BITS-1:0] target_cfg = mlws_pkg::TARGET_RESET;

   int  error_count = 0;
   int  quiet_cycles = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   bit  calm_phase = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shortest window predictor: push, then shrink from the oldest end
   function automatic bit predict_window(input array_item_type it,
                                         output window_result_type res);
      if (window_values.size() >= mlws_pkg::MAX_LEN) begin
         window_sum -= window_values.pop_front();
         store_overflowed = 1'b1;
      end
      window_values.push_back(it.value);
      window_sum += it.value;
      while (window_values.size() > 0 && window_sum >= longint'(target_cfg)) begin
         if (shortest_len == 0 || window_values.size() < shortest_len)
            shortest_len = mlws_pkg::LEN_BITS'(window_values.size());
         window_sum -= window_values.pop_front();
      end
      res = '0;
      if (!it.last)
         return 1'b0;
      res.min_length = shortest_len;
      res.overflow   = store_overflowed;
      window_values.delete();
      window_sum       = 0;
      shortest_len     = '0;
      store_overflowed = 1'b0;
      return 1'b1;
   endfunction

   // Item driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.value <= '0;
         req_chan.last  <= 1'b0;
         req_gap        <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_gap > 0) begin
            req_gap        <= req_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
            req_gap        <= $urandom_range(1, 14) - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_values.size() > 0) begin
            next_value     = pending_values.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.value <= next_value.value;
            req_chan.last  <= next_value.last;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall      <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall      <= rsp_stall - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
         rsp_stall      <= $urandom_range(1, 14) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Monitor, scoreboard and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            if (predict_window('{value: req_chan.value, last: req_chan.last}, want_result))
               expected_lengths.push_back(want_result);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_result = '{min_length: rsp_chan.min_length, overflow: rsp_chan.overflow};
            if (expected_lengths.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, got min_length %0d overflow %0b",
                        $time, got_result.min_length, got_result.overflow);
            end else begin
               want_result = expected_lengths.pop_front();
               if (got_result.min_length !== want_result.min_length) begin
                  error_count++;
                  $display("%0t: min_length expected %0d, got %0d",
                           $time, want_result.min_length, got_result.min_length);
               end
               if (got_result.overflow !== want_result.overflow) begin
                  error_count++;
                  $display("%0t: overflow expected %0b, got %0b",
                           $time, want_result.overflow, got_result.overflow);
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no progress for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic queue_value(input logic [mlws_pkg::VALUE_BITS-1:0] v, input logic is_last);
      pending_values.push_back('{value: v, last: is_last});
   endtask

   task automatic queue_array(input int len, input int vmax);
      logic [mlws_pkg::VALUE_BITS-1:0] v;
      for (int i = 0; i < len; i++) begin
         v = ($urandom_range(0, 15) == 0) ? mlws_pkg::VALUE_BITS'(65535)
                                          : mlws_pkg::VALUE_BITS'($urandom_range(1, vmax));
         queue_value(v, i == len - 1);
      end
   endtask

   task automatic drain_arrays();
      @(negedge clock);
      while (pending_values.size() != 0 || req_chan.valid || expected_lengths.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_target(input logic [mlws_pkg::TARGET_BITS-1:0] goal);
      repeat (8) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= goal;
      do
         @(posedge clock);
      while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      target_cfg = goal;
      @(negedge clock);
   endtask

   task automatic random_arrays(input logic [mlws_pkg::TARGET_BITS-1:0] goal,
                                input int n_items);
      int added;
      int len;
      int vmax;
      added = 0;
      write_target(goal);
      while (added < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
         case ($urandom_range(0, 3))
            0: vmax = 3;
            1: vmax = 255;
            2: vmax = 4095;
            default: vmax = 65535;
         endcase
         queue_array(len, vmax);
         added += len;
      end
      drain_arrays();
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      csr_chan.valid = 1'b0;
      csr_chan.data  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset target, zero target with a zero value, exact fits, unreachable
      queue_value(16'd1, 1'b1);
      queue_value(16'd65535, 1'b0);
      queue_value(16'd1, 1'b1);
      drain_arrays();
      write_target(32'd0);
      queue_value(16'd5, 1'b0);
      queue_value(16'd0, 1'b1);
      drain_arrays();
      write_target(32'd10);
      repeat (3) queue_value(16'd3, 1'b0);
      queue_value(16'd3, 1'b1);
      queue_value(16'd0, 1'b0);
      queue_value(16'd10, 1'b1);
      queue_value(16'd65535, 1'b0);
      queue_value(16'd1, 1'b1);
      drain_arrays();
      write_target(32'hFFFF_FFFF);
      queue_value(16'd65535, 1'b0);
      queue_value(16'd65535, 1'b0);
      queue_value(16'd65535, 1'b1);
      drain_arrays();

      random_arrays(32'd1, 120);
      random_arrays(32'd7, 120);
      random_arrays(32'd300, 120);
      random_arrays(32'd5000, 120);
      random_arrays(32'd70000, 120);
      random_arrays(32'd1000000, 120);
      random_arrays($urandom(), 120);
      random_arrays(32'hFFFF_FFFF, 120);

      calm_phase = 1'b1;
      random_arrays(32'd2000, 120);

      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
